// ===== rtl/core/prime_count_trial_division_macros.svh =====
// Assertion macros shared by the prime counter RTL.
`ifndef PRIME_COUNT_TRIAL_DIVISION_MACROS_SVH
`define PRIME_COUNT_TRIAL_DIVISION_MACROS_SVH

`ifndef ASSERT_OFF

// Checked property, ignored while reset is asserted.
`define PCTD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, also during reset.
`define PCTD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PCTD_ASSERT(label, clk, rst_n, prop, msg)
`define PCTD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/core/pctd_pkg.sv =====
// Shared constants and types for the trial-division prime counter.
package pctd_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Trial divisors start here; values below it are never prime.
  localparam int unsigned FIRST_DIVISOR   = 2;

  // Status of the shared remainder unit.
  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, remainder valid in the same cycle
    logic zero;   // remainder is zero
  } rem_stat_t;

endpackage

// ===== rtl/core/pctd_rem.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle.
module pctd_rem import pctd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output rem_stat_t              stat_o
);

  localparam int unsigned CW = $clog2(VALUE_WIDTH);
  localparam logic [CW-1:0] STEP_LAST = CW'(VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] dvd_q, dvd_d;
  logic [VALUE_WIDTH-1:0] div_q, div_d;
  logic [CW-1:0]          step_q, step_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   trial_sub;

  assign trial     = {rem_q, dvd_q[VALUE_WIDTH-1]};
  assign trial_sub = trial - {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      step_d = STEP_LAST;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // trial < 2*divisor, so one conditional subtract keeps rem < divisor
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial_sub[VALUE_WIDTH-1:0];
      end else begin
        rem_d = trial[VALUE_WIDTH-1:0];
      end
      dvd_d  = {dvd_q[VALUE_WIDTH-2:0], 1'b0};
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.zero = (rem_q == '0);

endmodule

// ===== rtl/core/prime_count_trial_division.sv =====
// Top level: sequencer, divisor stepping, prime count and result register.
//
//  port group | dir | tdata bits (low to high)             | tlast
//  s_axis     | in  | value[VALUE_WIDTH-1:0], zero pad      | last
//  m_axis     | out | is_prime, prime_count[COUNT_WIDTH], pad| last_out
//
// Values below two or negative go from accept straight to ST_FINISH.
// Otherwise each divisor is tried in turn in the shared
// remainder unit; divisors tried run 2..floor(sqrt(value)) at most.
// One item is in work at a time; s_axis_tready_o is high only when idle.
// The result register lets the next item be accepted while m_axis stalls.
// Reset clears the count and all control state; no clearing pass.
`include "prime_count_trial_division_macros.svh"
module prime_count_trial_division import pctd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int unsigned IN_TW  = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_TW = ((COUNT_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [IN_TW-1:0]  s_axis_tdata_i,   // value
  input  logic              s_axis_tlast_i,   // last
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_TW-1:0] m_axis_tdata_o,   // is_prime, prime_count
  output logic              m_axis_tlast_o    // last_out
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_e;

  localparam logic [VALUE_WIDTH-1:0] D_FIRST  = VALUE_WIDTH'(FIRST_DIVISOR);
  localparam logic [VALUE_WIDTH:0]   SQ_FIRST = (VALUE_WIDTH + 1)'(FIRST_DIVISOR * FIRST_DIVISOR);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;

  state_e                 state_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic                   last_q;
  logic                   prime_q;
  logic [VALUE_WIDTH-1:0] d_q;
  logic [VALUE_WIDTH:0]   sq_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic                   out_valid_q;
  logic                   out_prime_q;
  logic [COUNT_WIDTH-1:0] out_cnt_q;
  logic                   out_last_q;

  logic [VALUE_WIDTH-1:0] in_val;
  logic                   in_acc;
  logic                   in_small;
  logic                   sq_in_range;
  logic                   rem_start;
  logic                   out_free;
  logic [COUNT_WIDTH-1:0] cnt_next;
  rem_stat_t              rem_stat;

  assign in_val          = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  // negative, zero or one
  assign in_small        = in_val[VALUE_WIDTH-1] || (in_val[VALUE_WIDTH-1:1] == '0);
  assign sq_in_range     = (sq_q <= {1'b0, val_q});
  assign rem_start       = (state_q == ST_CHECK) && sq_in_range;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign cnt_next        = (prime_q && (cnt_q != CNT_MAX)) ? cnt_q + 1'b1 : cnt_q;

  pctd_rem #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (val_q),
    .divisor_i  (d_q),
    .stat_o     (rem_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      prime_q     <= 1'b0;
    end else begin
      // a finishing item reloads the register in ST_FINISH below
      if (out_valid_q && m_axis_tready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            prime_q <= 1'b0;
            state_q <= in_small ? ST_FINISH : ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!sq_in_range) begin
            // no divisor up to the square root: prime
            prime_q <= 1'b1;
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_stat.done) begin
            state_q <= rem_stat.zero ? ST_FINISH : ST_CHECK;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            cnt_q       <= last_q ? '0 : cnt_next;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload: item capture, divisor and square stepping, result register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      val_q  <= in_val;
      last_q <= s_axis_tlast_i;
      d_q    <= D_FIRST;
      sq_q   <= SQ_FIRST;
    end
    if ((state_q == ST_DIV) && rem_stat.done) begin
      // (d+1)^2 = d^2 + 2d + 1
      sq_q <= sq_q + {d_q, 1'b1};
      d_q  <= d_q + 1'b1;
    end
    if ((state_q == ST_FINISH) && out_free) begin
      out_prime_q <= prime_q;
      out_cnt_q   <= cnt_next;
      out_last_q  <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = OUT_TW'({out_cnt_q, out_prime_q});

  `PCTD_ASSERT(a_ready_unit_idle, clk_i, rst_ni, s_axis_tready_o |-> !rem_stat.busy, "remainder unit busy while accepting")
  `PCTD_ASSERT(a_done_in_div, clk_i, rst_ni, rem_stat.done |-> (state_q == ST_DIV), "remainder done outside divide state")
  `PCTD_ASSERT(a_divisor_floor, clk_i, rst_ni, (state_q == ST_DIV) |-> (d_q >= D_FIRST) && (d_q < val_q), "trial divisor out of range")
  `PCTD_ASSERT(a_finish_loads, clk_i, rst_ni, ((state_q == ST_FINISH) && out_free) |=> out_valid_q && (state_q == ST_IDLE), "finished item not loaded into result register")

endmodule

// ===== tb/prime_count_trial_division_test.sv =====
// Self-checking stream testbench for the trial-division prime counter.
module prime_count_trial_division_test import pctd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW = VALUE_WIDTH_DEF;
  localparam int unsigned CW = COUNT_WIDTH_DEF;
  localparam int unsigned IN_TW = ((VW + 7) / 8) * 8;
  localparam int unsigned OUT_TW = ((CW + 1 + 7) / 8) * 8;
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 78;

  typedef struct {
    logic [VW-1:0] value;
    bit last;
  } test_item_t;

  typedef struct {
    bit is_prime;
    logic [CW-1:0] count;
    bit last;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TW-1:0] s_axis_tdata = '0;   // value
  logic s_axis_tlast = 1'b0;             // last
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TW-1:0] m_axis_tdata;       // is_prime, prime_count, pad
  logic m_axis_tlast;                    // last_out

  test_item_t items_to_send[$];
  verdict_t verdicts_due[$];
  logic [CW-1:0] primes_in_array = '0;
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  test_item_t nxt_item;
  verdict_t got;
  verdict_t want;

  prime_count_trial_division dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit prime_by_trial(logic [VW-1:0] v);
    longint unsigned n;
    longint unsigned d;
    if (v[VW-1]) return 1'b0;
    n = v;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Running count per array; saturates, clears after a last item.
  task automatic tally_item(test_item_t it);
    verdict_t v;
    v.is_prime = prime_by_trial(it.value);
    if (v.is_prime && primes_in_array != '1) primes_in_array = primes_in_array + 1'b1;
    v.count = primes_in_array;
    v.last = it.last;
    verdicts_due.push_back(v);
    if (it.last) primes_in_array = '0;
  endtask

  function automatic test_item_t mk(logic [VW-1:0] value, bit last);
    test_item_t it;
    it.value = value;
    it.last = last;
    return it;
  endfunction

  function automatic logic [VW-1:0] random_value();
    logic [VW-1:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(0, 200);
      2, 3, 4, 5: return $urandom_range(0, 20000);
      6: return r | (1 << (VW - 1));
      7: begin
        // large, but even so the divider stops at once
        r[VW-1] = 1'b0;
        r[0] = 1'b0;
        return r;
      end
      8: begin
        r[VW-1] = 1'b0;
        return r - (r % 3);
      end
      default: return $urandom_range(20000, 65535);
    endcase
  endfunction

  // Sender: bursts of random length, random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        tally_item(mk(s_axis_tdata[VW-1:0], s_axis_tlast));
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered item
      end else if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (items_to_send.size() != 0) begin
        nxt_item = items_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_TW'(nxt_item.value);
        s_axis_tlast <= nxt_item.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches between free, patchy and heavy
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_mode <= 0;
      rx_left <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_left <= $urandom_range(4, 60);
      end else begin
        rx_left <= rx_left - 1;
      end
      if (rx_mode == 0) m_axis_tready <= 1'b1;
      else if (rx_mode == 1) m_axis_tready <= $urandom_range(0, 1);
      else m_axis_tready <= ($urandom_range(0, 4) == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.is_prime = m_axis_tdata[0];
      got.count = m_axis_tdata[CW:1];
      got.last = m_axis_tlast;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected item: is_prime=%0b count=%0d last=%0b",
                 $time, got.is_prime, got.count, got.last);
        failures++;
      end else begin
        want = verdicts_due.pop_front();
        if (got.is_prime !== want.is_prime) begin
          $display("%0t: is_prime mismatch: expected %0b, actual %0b",
                   $time, want.is_prime, got.is_prime);
          failures++;
        end
        if (got.count !== want.count) begin
          $display("%0t: prime_count mismatch: expected %0d, actual %0d",
                   $time, want.count, got.count);
          failures++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_out mismatch: expected %0b, actual %0b",
                   $time, want.last, got.last);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic drain();
    while (items_to_send.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned run_len;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: sign extremes, zero, one, small primes, squares, slow prime
    items_to_send.push_back(mk(32'd0, 1'b0));
    items_to_send.push_back(mk(32'd1, 1'b0));
    items_to_send.push_back(mk(32'd2, 1'b0));
    items_to_send.push_back(mk(32'd3, 1'b0));
    items_to_send.push_back(mk(32'd4, 1'b0));
    items_to_send.push_back(mk(32'd5, 1'b1));
    items_to_send.push_back(mk(32'hFFFF_FFFF, 1'b0));
    items_to_send.push_back(mk(32'hFFFF_FFFE, 1'b0));
    items_to_send.push_back(mk(32'h8000_0000, 1'b0));
    items_to_send.push_back(mk(-32'sd7, 1'b0));
    items_to_send.push_back(mk(32'h7FFF_FFFE, 1'b0));
    items_to_send.push_back(mk(32'h5555_5555, 1'b0));
    items_to_send.push_back(mk(32'hAAAA_AAAA, 1'b0));
    items_to_send.push_back(mk(32'd25, 1'b0));
    items_to_send.push_back(mk(32'd49, 1'b0));
    items_to_send.push_back(mk(32'd121, 1'b0));
    items_to_send.push_back(mk(32'd97, 1'b0));
    items_to_send.push_back(mk(32'd65521, 1'b0));
    items_to_send.push_back(mk(32'd1000001, 1'b0));
    items_to_send.push_back(mk(32'd1000003, 1'b1));
    items_to_send.push_back(mk(32'd7, 1'b1));
    items_to_send.push_back(mk(32'd8, 1'b1));

    // random arrays of random length, last mark on the final element
    n = 0;
    while (n < RANDOM_ITEMS) begin
      run_len = $urandom_range(1, 12);
      for (int unsigned k = 0; k < run_len; k++) begin
        items_to_send.push_back(mk(random_value(), k == run_len - 1));
      end
      n += run_len;
    end
    drain();

    repeat (60) @(posedge clk_i);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
